@@ sv/mmot_pkg.sv @@
// Shared types and codes for the multi-mode output timer.
package mmot_pkg;

  localparam int unsigned COIL_COUNT_DEF = 256;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned MODE_W  = 3;
  localparam int unsigned COIL_W  = 8;
  localparam int unsigned PHASE_W = 2;
  localparam int unsigned LVL_W   = 3;
  localparam int unsigned REG_W   = 3;

  localparam logic [MODE_W-1:0] MODE_OFF  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SHOT = 3'd1;
  localparam logic [MODE_W-1:0] MODE_MONO = 3'd2;
  localparam logic [MODE_W-1:0] MODE_OSC  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_EDGE = 3'd4;

  localparam logic [REG_W-1:0] REG_MODE    = 3'd0;
  localparam logic [REG_W-1:0] REG_DUR_A   = 3'd1;
  localparam logic [REG_W-1:0] REG_DUR_B   = 3'd2;
  localparam logic [REG_W-1:0] REG_DUR_C   = 3'd3;
  localparam logic [REG_W-1:0] REG_LEVELS  = 3'd4;
  localparam logic [REG_W-1:0] REG_TRIG_RE = 3'd5;
  localparam logic [REG_W-1:0] REG_COIL    = 3'd6;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_COIL = 1'b1;

  localparam logic [PHASE_W-1:0] PH_0 = 2'd0;
  localparam logic [PHASE_W-1:0] PH_1 = 2'd1;
  localparam logic [PHASE_W-1:0] PH_2 = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [TIME_W-1:0] dur_a;
    logic [TIME_W-1:0] dur_b;
    logic [TIME_W-1:0] dur_c;
    logic [LVL_W-1:0]  levels;
    logic              trig_rising;
    logic [COIL_W-1:0] coil;
  } cfg_t;

  typedef struct packed {
    logic               active;
    logic [PHASE_W-1:0] phase;
    logic [TIME_W-1:0]  phase_start;
    logic               prev_in;
    logic [TIME_W-1:0]  last_time;
  } state_t;

  typedef struct packed {
    logic               drive_valid;
    logic               coil_level;
    logic               running;
    logic [PHASE_W-1:0] phase_now;
  } result_t;

endpackage

@@ sv/mmot_step.sv @@
// Next-state and result logic for one tick or coil write request.
module mmot_step #(
  parameter int unsigned COIL_COUNT = mmot_pkg::COIL_COUNT_DEF
) (
  input  mmot_pkg::cfg_t                    cfg,
  input  mmot_pkg::state_t                  st,
  input  logic                              in_opcode,
  input  logic [mmot_pkg::TIME_W-1:0]       in_time_ms,
  input  logic                              in_input_level,
  input  logic [mmot_pkg::COIL_W-1:0]       in_coil_index,
  output mmot_pkg::state_t                  st_nxt,
  output mmot_pkg::result_t                 res
);

  function automatic logic expired(input logic [mmot_pkg::TIME_W-1:0] now,
                                   input logic [mmot_pkg::TIME_W-1:0] start,
                                   input logic [mmot_pkg::TIME_W-1:0] dur);
    logic [mmot_pkg::TIME_W-1:0] diff;
    diff = now - start;
    return diff >= dur;
  endfunction

  logic             coil_ok;
  logic             enabled;
  logic             drv_req;
  logic             drv_lvl;
  logic             hit;
  mmot_pkg::state_t nxt;

  assign coil_ok = (32'(cfg.coil) < COIL_COUNT);
  assign enabled = (cfg.mode >= mmot_pkg::MODE_SHOT) && (cfg.mode <= mmot_pkg::MODE_EDGE);
  assign hit = cfg.trig_rising ? (!st.prev_in && in_input_level)
                               : (st.prev_in && !in_input_level);

  always_comb begin
    nxt = st;
    nxt.last_time = in_time_ms;
    drv_req = 1'b0;
    drv_lvl = 1'b0;
    if (in_opcode == mmot_pkg::OP_TICK) begin
      unique case (cfg.mode)
        mmot_pkg::MODE_SHOT: begin
          if (st.active) begin
            if (st.phase == mmot_pkg::PH_0) begin
              drv_req = 1'b1;
              drv_lvl = cfg.levels[0];
              if (cfg.dur_a == '0 || expired(in_time_ms, st.phase_start, cfg.dur_a)) begin
                nxt.phase = mmot_pkg::PH_1;
                nxt.phase_start = in_time_ms;
              end
            end else if (st.phase == mmot_pkg::PH_1) begin
              drv_req = 1'b1;
              drv_lvl = cfg.levels[1];
              if (cfg.dur_b == '0 || expired(in_time_ms, st.phase_start, cfg.dur_b)) begin
                nxt.phase = mmot_pkg::PH_2;
                nxt.phase_start = in_time_ms;
              end
            end else if (st.phase == mmot_pkg::PH_2) begin
              drv_req = 1'b1;
              drv_lvl = cfg.levels[2];
              if (cfg.dur_c == '0 || expired(in_time_ms, st.phase_start, cfg.dur_c)) begin
                nxt.active = 1'b0;
                nxt.phase = mmot_pkg::PH_0;
              end
            end else begin
              nxt.active = 1'b0;
              nxt.phase = mmot_pkg::PH_0;
            end
          end
        end
        mmot_pkg::MODE_MONO: begin
          if (!st.active) begin
            drv_req = 1'b1;
            drv_lvl = cfg.levels[0];
          end else if (st.phase == mmot_pkg::PH_0) begin
            nxt.phase = mmot_pkg::PH_1;
            nxt.phase_start = in_time_ms;
            drv_req = 1'b1;
            drv_lvl = cfg.levels[1];
          end else if (st.phase == mmot_pkg::PH_1 &&
                       expired(in_time_ms, st.phase_start, cfg.dur_a)) begin
            drv_req = 1'b1;
            drv_lvl = cfg.levels[0];
            nxt.active = 1'b0;
            nxt.phase = mmot_pkg::PH_0;
          end
        end
        mmot_pkg::MODE_OSC: begin
          if (st.active) begin
            if (st.phase == mmot_pkg::PH_0) begin
              drv_req = 1'b1;
              drv_lvl = cfg.levels[0];
              if (cfg.dur_a == '0 || expired(in_time_ms, st.phase_start, cfg.dur_a)) begin
                nxt.phase = mmot_pkg::PH_1;
                nxt.phase_start = in_time_ms;
              end
            end else begin
              drv_req = 1'b1;
              drv_lvl = cfg.levels[1];
              if (cfg.dur_b == '0 || expired(in_time_ms, st.phase_start, cfg.dur_b)) begin
                nxt.phase = mmot_pkg::PH_0;
                nxt.phase_start = in_time_ms;
              end
            end
          end
        end
        mmot_pkg::MODE_EDGE: begin
          nxt.prev_in = in_input_level;
          if (hit) begin
            if (cfg.dur_a == '0) begin
              drv_req = 1'b1;
              drv_lvl = cfg.levels[0];
              nxt.active = 1'b1;
              nxt.phase = mmot_pkg::PH_1;
              nxt.phase_start = in_time_ms;
            end else if (!st.active) begin
              nxt.active = 1'b1;
              nxt.phase = mmot_pkg::PH_0;
              nxt.phase_start = in_time_ms;
            end
          end
          if (nxt.active && cfg.dur_a != '0 && nxt.phase == mmot_pkg::PH_0 &&
              expired(in_time_ms, nxt.phase_start, cfg.dur_a)) begin
            drv_req = 1'b1;
            drv_lvl = cfg.levels[0];
            nxt.phase = mmot_pkg::PH_1;
          end
          if (nxt.active && nxt.phase == mmot_pkg::PH_1) begin
            drv_req = 1'b1;
            drv_lvl = cfg.levels[0];
          end
        end
        default: begin
        end
      endcase
    end else if (enabled && cfg.coil == in_coil_index &&
                 !(cfg.mode == mmot_pkg::MODE_OSC && st.active)) begin
      nxt.active = 1'b1;
      nxt.phase = mmot_pkg::PH_0;
      nxt.phase_start = in_time_ms;
    end
  end

  assign st_nxt = nxt;
  assign res.drive_valid = drv_req & coil_ok;
  assign res.coil_level  = drv_req & coil_ok & drv_lvl;
  assign res.running     = nxt.active;
  assign res.phase_now   = nxt.phase;

endmodule

@@ sv/multi_mode_output_timer_core.sv @@
// Top level of the multi-mode output timer: config registers, timer state, result register.
// One timer channel driving one output coil in one-shot, monostable, astable or
// input-triggered mode. Every request (a tick with time stamp and input level, or a
// coil write) yields exactly one result in the cycle after acceptance; a new request is
// taken every cycle, the only limit being the single result register, which stalls
// the input only while it holds a result the receiver has not taken. Configuration
// writes are always ready, and writes to a defined register clear the run state (astable
// mode restarts from the last seen time stamp).
module multi_mode_output_timer_core #(
  parameter int unsigned COIL_COUNT = mmot_pkg::COIL_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_opcode,
  input  logic [mmot_pkg::TIME_W-1:0]    in_time_ms,
  input  logic                           in_input_level,
  input  logic [mmot_pkg::COIL_W-1:0]    in_coil_index,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_drive_valid,
  output logic                           out_coil_level,
  output logic                           out_running,
  output logic [mmot_pkg::PHASE_W-1:0]   out_phase_now,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mmot_pkg::REG_W-1:0]     cfg_index,
  input  logic [mmot_pkg::TIME_W-1:0]    cfg_data
);

  mmot_pkg::cfg_t    cfg_r, cfg_nxt;
  mmot_pkg::state_t  st_r, st_nxt, step_st;
  mmot_pkg::result_t res_r, step_res;
  logic              out_valid_r;
  logic              in_acc;
  logic              cfg_wr;
  logic              cfg_hit;

  assign in_stall  = out_valid_r & out_stall;
  assign in_acc    = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;

  mmot_step #(.COIL_COUNT(COIL_COUNT)) u_step (
    .cfg           (cfg_r),
    .st            (st_r),
    .in_opcode     (in_opcode),
    .in_time_ms    (in_time_ms),
    .in_input_level(in_input_level),
    .in_coil_index (in_coil_index),
    .st_nxt        (step_st),
    .res           (step_res)
  );

  always_comb begin
    cfg_nxt = cfg_r;
    cfg_hit = 1'b1;
    unique case (cfg_index)
      mmot_pkg::REG_MODE:    cfg_nxt.mode = cfg_data[mmot_pkg::MODE_W-1:0];
      mmot_pkg::REG_DUR_A:   cfg_nxt.dur_a = cfg_data;
      mmot_pkg::REG_DUR_B:   cfg_nxt.dur_b = cfg_data;
      mmot_pkg::REG_DUR_C:   cfg_nxt.dur_c = cfg_data;
      mmot_pkg::REG_LEVELS:  cfg_nxt.levels = cfg_data[mmot_pkg::LVL_W-1:0];
      mmot_pkg::REG_TRIG_RE: cfg_nxt.trig_rising = cfg_data[0];
      mmot_pkg::REG_COIL:    cfg_nxt.coil = cfg_data[mmot_pkg::COIL_W-1:0];
      default:               cfg_hit = 1'b0;
    endcase
  end

  always_comb begin
    st_nxt = st_r;
    if (cfg_wr && cfg_hit) begin
      st_nxt.active      = (cfg_nxt.mode == mmot_pkg::MODE_OSC);
      st_nxt.phase       = mmot_pkg::PH_0;
      st_nxt.phase_start = (cfg_nxt.mode == mmot_pkg::MODE_OSC) ? st_r.last_time : '0;
    end else if (in_acc) begin
      st_nxt = step_st;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= '0;
      st_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        cfg_r <= cfg_nxt;
      end
      st_r <= st_nxt;
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= step_res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_drive_valid = res_r.drive_valid;
  assign out_coil_level  = res_r.coil_level;
  assign out_running     = res_r.running;
  assign out_phase_now   = res_r.phase_now;

  a_level_needs_drive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !res_r.drive_valid |-> !res_r.coil_level)
    else $error("coil level set without drive");

  a_idle_phase_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !st_r.active |-> st_r.phase == mmot_pkg::PH_0)
    else $error("inactive timer with nonzero phase");

  a_cfg_clears_run: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr && cfg_hit |=> st_r.active == (cfg_r.mode == mmot_pkg::MODE_OSC) &&
                          st_r.phase == mmot_pkg::PH_0)
    else $error("config write did not reset run state");

  a_coil_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.drive_valid |-> 32'(cfg_r.coil) < COIL_COUNT)
    else $error("drive on out-of-range coil");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r)
    else $error("input stalled with empty result register");

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the multi-mode output timer core: directed table, then random runs.
module tb_top;

  localparam int unsigned COIL_COUNT     = mmot_pkg::COIL_COUNT_DEF;
  localparam logic [mmot_pkg::REG_W-1:0] REG_NONE = 3'd7;
  localparam int          SEGMENTS       = 30;
  localparam int          SEG_ITEMS      = 40;
  localparam int          HOLD_SEG       = 2;
  localparam int          HOLD_LEN       = 150;
  localparam int          GAP_PCT        = 23;
  localparam int          END_SETTLE     = 10;
  localparam int          WATCHDOG_LIMIT = 1000;
  localparam logic [31:0] REG_MASK [7]   = '{32'h7, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                             32'hFFFF_FFFF, 32'h7, 32'h1, 32'hFF};
  localparam mmot_pkg::result_t IDLE_RES = '0;
  localparam mmot_pkg::result_t ARMED_RES = '{drive_valid: 1'b0, coil_level: 1'b0,
                                              running: 1'b1, phase_now: mmot_pkg::PH_0};

  typedef enum logic {ROW_CFG, ROW_REQ} row_kind_t;

  typedef struct {
    row_kind_t                    kind;
    logic [mmot_pkg::REG_W-1:0]   reg_idx;
    logic                         op;
    logic [mmot_pkg::TIME_W-1:0]  value;
    logic                         level;
    logic [mmot_pkg::COIL_W-1:0]  coil;
    logic                         typed;
    mmot_pkg::result_t            want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid, in_stall, in_opcode, in_input_level;
  logic [mmot_pkg::TIME_W-1:0]  in_time_ms;
  logic [mmot_pkg::COIL_W-1:0]  in_coil_index;
  logic out_valid, out_stall, out_drive_valid, out_coil_level, out_running;
  logic [mmot_pkg::PHASE_W-1:0] out_phase_now;
  logic cfg_valid, cfg_ready;
  logic [mmot_pkg::REG_W-1:0]   cfg_index;
  logic [mmot_pkg::TIME_W-1:0]  cfg_data;

  logic hold_toggle;
  logic no_gaps;
  int   mismatches = 0;

  mmot_pkg::cfg_t    regs;
  mmot_pkg::state_t  st;
  logic              drv_on, drv_lvl;
  mmot_pkg::result_t timer_results_q[$];
  dir_row_t          dir_tab[$];

  multi_mode_output_timer_core #(.COIL_COUNT(COIL_COUNT)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_opcode(in_opcode),
    .in_time_ms(in_time_ms), .in_input_level(in_input_level), .in_coil_index(in_coil_index),
    .out_valid(out_valid), .out_stall(out_stall), .out_drive_valid(out_drive_valid),
    .out_coil_level(out_coil_level), .out_running(out_running),
    .out_phase_now(out_phase_now),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void drive_coil(input logic lvl);
    if (32'(regs.coil) < COIL_COUNT) begin
      drv_on  = 1'b1;
      drv_lvl = lvl;
    end
  endfunction

  function automatic logic span_done(input logic [mmot_pkg::TIME_W-1:0] now,
                                     input logic [mmot_pkg::TIME_W-1:0] dur);
    logic [mmot_pkg::TIME_W-1:0] span;
    span = now - st.phase_start;
    return span >= dur;
  endfunction

  task automatic advance_timer(input logic op, input logic [mmot_pkg::TIME_W-1:0] now,
                               input logic lvl_in, input logic [mmot_pkg::COIL_W-1:0] idx,
                               output mmot_pkg::result_t res);
    logic prev, hit;
    drv_on = 1'b0;
    drv_lvl = 1'b0;
    st.last_time = now;
    if (op == mmot_pkg::OP_TICK) begin
      case (regs.mode)
        mmot_pkg::MODE_SHOT: begin
          if (st.active) begin
            if (st.phase == mmot_pkg::PH_0) begin
              drive_coil(regs.levels[0]);
              if (regs.dur_a == 0 || span_done(now, regs.dur_a)) begin
                st.phase = mmot_pkg::PH_1;
                st.phase_start = now;
              end
            end else if (st.phase == mmot_pkg::PH_1) begin
              drive_coil(regs.levels[1]);
              if (regs.dur_b == 0 || span_done(now, regs.dur_b)) begin
                st.phase = mmot_pkg::PH_2;
                st.phase_start = now;
              end
            end else if (st.phase == mmot_pkg::PH_2) begin
              drive_coil(regs.levels[2]);
              if (regs.dur_c == 0 || span_done(now, regs.dur_c)) begin
                st.active = 1'b0;
                st.phase = mmot_pkg::PH_0;
              end
            end else begin
              st.active = 1'b0;
              st.phase = mmot_pkg::PH_0;
            end
          end
        end
        mmot_pkg::MODE_MONO: begin
          if (!st.active) begin
            drive_coil(regs.levels[0]);
          end else if (st.phase == mmot_pkg::PH_0) begin
            st.phase = mmot_pkg::PH_1;
            st.phase_start = now;
            drive_coil(regs.levels[1]);
          end else if (st.phase == mmot_pkg::PH_1 && span_done(now, regs.dur_a)) begin
            drive_coil(regs.levels[0]);
            st.active = 1'b0;
            st.phase = mmot_pkg::PH_0;
          end
        end
        mmot_pkg::MODE_OSC: begin
          if (st.active) begin
            if (st.phase == mmot_pkg::PH_0) begin
              drive_coil(regs.levels[0]);
              if (regs.dur_a == 0 || span_done(now, regs.dur_a)) begin
                st.phase = mmot_pkg::PH_1;
                st.phase_start = now;
              end
            end else begin
              drive_coil(regs.levels[1]);
              if (regs.dur_b == 0 || span_done(now, regs.dur_b)) begin
                st.phase = mmot_pkg::PH_0;
                st.phase_start = now;
              end
            end
          end
        end
        mmot_pkg::MODE_EDGE: begin
          prev = st.prev_in;
          st.prev_in = lvl_in;
          hit = regs.trig_rising ? (!prev && lvl_in) : (prev && !lvl_in);
          if (hit) begin
            if (regs.dur_a == 0) begin
              drive_coil(regs.levels[0]);
              st.active = 1'b1;
              st.phase = mmot_pkg::PH_1;
              st.phase_start = now;
            end else if (!st.active) begin
              st.active = 1'b1;
              st.phase = mmot_pkg::PH_0;
              st.phase_start = now;
            end
          end
          if (st.active && regs.dur_a != 0 && st.phase == mmot_pkg::PH_0 &&
              span_done(now, regs.dur_a)) begin
            drive_coil(regs.levels[0]);
            st.phase = mmot_pkg::PH_1;
          end
          if (st.active && st.phase == mmot_pkg::PH_1) drive_coil(regs.levels[0]);
        end
        default: ;
      endcase
    end else if (regs.mode >= mmot_pkg::MODE_SHOT && regs.mode <= mmot_pkg::MODE_EDGE &&
                 regs.coil == idx && !(regs.mode == mmot_pkg::MODE_OSC && st.active)) begin
      st.active = 1'b1;
      st.phase = mmot_pkg::PH_0;
      st.phase_start = now;
    end
    res = {drv_on, drv_lvl, st.active, st.phase};
  endtask

  task automatic apply_reg_write(input logic [mmot_pkg::REG_W-1:0] idx,
                                 input logic [mmot_pkg::TIME_W-1:0] data);
    case (idx)
      mmot_pkg::REG_MODE:    regs.mode = data[mmot_pkg::MODE_W-1:0];
      mmot_pkg::REG_DUR_A:   regs.dur_a = data;
      mmot_pkg::REG_DUR_B:   regs.dur_b = data;
      mmot_pkg::REG_DUR_C:   regs.dur_c = data;
      mmot_pkg::REG_LEVELS:  regs.levels = data[mmot_pkg::LVL_W-1:0];
      mmot_pkg::REG_TRIG_RE: regs.trig_rising = data[0];
      mmot_pkg::REG_COIL:    regs.coil = data[mmot_pkg::COIL_W-1:0];
      default:               return;
    endcase
    st.active = 1'b0;
    st.phase = mmot_pkg::PH_0;
    st.phase_start = '0;
    if (regs.mode == mmot_pkg::MODE_OSC) begin
      st.active = 1'b1;
      st.phase_start = st.last_time;
    end
  endtask

  function automatic dir_row_t req_row(input logic op, input logic [mmot_pkg::TIME_W-1:0] stamp,
                                       input logic lvl,
                                       input logic [mmot_pkg::COIL_W-1:0] idx);
    dir_row_t row;
    row = '{kind: ROW_REQ, reg_idx: mmot_pkg::REG_MODE, op: op, value: stamp, level: lvl,
            coil: idx, typed: 1'b0, want: IDLE_RES};
    return row;
  endfunction

  function automatic dir_row_t chk_row(input logic op, input logic [mmot_pkg::TIME_W-1:0] stamp,
                                       input logic lvl,
                                       input logic [mmot_pkg::COIL_W-1:0] idx,
                                       input mmot_pkg::result_t want);
    dir_row_t row;
    row = req_row(op, stamp, lvl, idx);
    row.typed = 1'b1;
    row.want = want;
    return row;
  endfunction

  function automatic dir_row_t cfg_row(input logic [mmot_pkg::REG_W-1:0] idx,
                                       input logic [mmot_pkg::TIME_W-1:0] data);
    dir_row_t row;
    row = '{kind: ROW_CFG, reg_idx: idx, op: mmot_pkg::OP_TICK, value: data, level: 1'b0,
            coil: '0, typed: 1'b0, want: IDLE_RES};
    return row;
  endfunction

  function automatic logic [mmot_pkg::TIME_W-1:0] pick_duration();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10) return '0;
    if (roll < 15) return 32'hFFFF_FFFF;
    if (roll < 20) return $urandom();
    return $urandom_range(1, 12);
  endfunction

  task automatic send_req(input logic op, input logic [mmot_pkg::TIME_W-1:0] stamp,
                          input logic lvl, input logic [mmot_pkg::COIL_W-1:0] idx,
                          input logic typed, input mmot_pkg::result_t want);
    mmot_pkg::result_t res;
    while (!no_gaps && $urandom_range(99) < GAP_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_time_ms     <= stamp;
    in_input_level <= lvl;
    in_coil_index  <= idx;
    do @(posedge clk); while (in_stall);
    advance_timer(op, stamp, lvl, idx, res);
    timer_results_q.push_back(typed ? want : res);
  endtask

  task automatic write_reg(input logic [mmot_pkg::REG_W-1:0] idx,
                           input logic [mmot_pkg::TIME_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_reg_write(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (timer_results_q.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // result side: random stall, one long hold-off on request, compare against oldest expectation
  initial begin : result_check
    int                hold_left;
    logic              hold_seen;
    mmot_pkg::result_t got, want;
    hold_left = 0;
    hold_seen = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got = {out_drive_valid, out_coil_level, out_running, out_phase_now};
        if (timer_results_q.size() == 0) begin
          $display("%0t: unexpected result dv=%0b lvl=%0b run=%0b ph=%0d", $time,
                   got.drive_valid, got.coil_level, got.running, got.phase_now);
          mismatches++;
        end else begin
          want = timer_results_q.pop_front();
          if (got.drive_valid !== want.drive_valid || got.coil_level !== want.coil_level ||
              got.running !== want.running || got.phase_now !== want.phase_now) begin
            $display("%0t: mismatch expected dv=%0b lvl=%0b run=%0b ph=%0d", $time,
                     want.drive_valid, want.coil_level, want.running, want.phase_now);
            $display("%0t:          actual   dv=%0b lvl=%0b run=%0b ph=%0d", $time,
                     got.drive_valid, got.coil_level, got.running, got.phase_now);
            mismatches++;
          end
        end
      end
      if (hold_toggle !== hold_seen) begin
        hold_seen = hold_toggle;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !no_gaps && ($urandom_range(99) < GAP_PCT);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("[multi_mode_output_timer_core] ERROR");
    $finish;
  end

  initial begin : stimulus
    logic [mmot_pkg::TIME_W-1:0] vals [7];
    logic [mmot_pkg::TIME_W-1:0] stamp;
    logic                        level, op;
    logic [mmot_pkg::COIL_W-1:0] idx;
    int unsigned                 roll, first;
    int                          seg, k, r;

    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_opcode      <= mmot_pkg::OP_TICK;
    in_time_ms     <= '0;
    in_input_level <= 1'b0;
    in_coil_index  <= '0;
    cfg_valid      <= 1'b0;
    cfg_index      <= mmot_pkg::REG_MODE;
    cfg_data       <= '0;
    hold_toggle    <= 1'b0;
    no_gaps        <= 1'b0;
    regs = '0;
    st   = '0;

    // disabled after reset
    dir_tab.push_back(chk_row(mmot_pkg::OP_TICK, 32'd0, 1'b0, 8'd0, IDLE_RES));
    dir_tab.push_back(chk_row(mmot_pkg::OP_COIL, 32'd5, 1'b0, 8'd0, IDLE_RES));
    // one-shot, phase 2 at max duration across the wrap
    dir_tab.push_back(cfg_row(mmot_pkg::REG_DUR_A, 32'd10));
    dir_tab.push_back(cfg_row(mmot_pkg::REG_DUR_B, 32'd0));
    dir_tab.push_back(cfg_row(mmot_pkg::REG_DUR_C, 32'hFFFF_FFFF));
    dir_tab.push_back(cfg_row(mmot_pkg::REG_LEVELS, 32'd5));
    dir_tab.push_back(cfg_row(mmot_pkg::REG_COIL, 32'd255));
    dir_tab.push_back(cfg_row(mmot_pkg::REG_MODE, 32'(mmot_pkg::MODE_SHOT)));
    dir_tab.push_back(chk_row(mmot_pkg::OP_COIL, 32'd100, 1'b0, 8'd255, ARMED_RES));
    dir_tab.push_back(req_row(mmot_pkg::OP_TICK, 32'd105, 1'b0, 8'd0));
    dir_tab.push_back(req_row(mmot_pkg::OP_TICK, 32'd110, 1'b0, 8'd0));
    dir_tab.push_back(req_row(mmot_pkg::OP_TICK, 32'd111, 1'b0, 8'd0));
    dir_tab.push_back(req_row(mmot_pkg::OP_TICK, 32'd0, 1'b0, 8'd0));
    dir_tab.push_back(req_row(mmot_pkg::OP_TICK, 32'd110, 1'b0, 8'd0));
    // monostable with retrigger
    dir_tab.push_back(cfg_row(mmot_pkg::REG_DUR_A, 32'd20));
    dir_tab.push_back(cfg_row(mmot_pkg::REG_MODE, 32'(mmot_pkg::MODE_MONO)));
    dir_tab.push_back(req_row(mmot_pkg::OP_TICK, 32'd200, 1'b0, 8'd0));
    dir_tab.push_back(req_row(mmot_pkg::OP_COIL, 32'd201, 1'b0, 8'd255));
    dir_tab.push_back(req_row(mmot_pkg::OP_TICK, 32'd202, 1'b0, 8'd0));
    dir_tab.push_back(req_row(mmot_pkg::OP_COIL, 32'd210, 1'b0, 8'd255));
    dir_tab.push_back(req_row(mmot_pkg::OP_TICK, 32'd215, 1'b0, 8'd0));
    dir_tab.push_back(req_row(mmot_pkg::OP_TICK, 32'd235, 1'b0, 8'd0));
    // astable auto-start from last time, coil write ignored while running
    dir_tab.push_back(cfg_row(mmot_pkg::REG_DUR_A, 32'd0));
    dir_tab.push_back(cfg_row(mmot_pkg::REG_DUR_B, 32'd3));
    dir_tab.push_back(cfg_row(mmot_pkg::REG_MODE, 32'(mmot_pkg::MODE_OSC)));
    dir_tab.push_back(req_row(mmot_pkg::OP_TICK, 32'd236, 1'b0, 8'd0));
    dir_tab.push_back(req_row(mmot_pkg::OP_COIL, 32'd237, 1'b0, 8'd255));
    dir_tab.push_back(req_row(mmot_pkg::OP_TICK, 32'd238, 1'b0, 8'd0));
    dir_tab.push_back(req_row(mmot_pkg::OP_TICK, 32'd239, 1'b0, 8'd0));
    // input-triggered: rising with delay, then falling with zero delay
    dir_tab.push_back(cfg_row(mmot_pkg::REG_LEVELS, 32'd7));
    dir_tab.push_back(cfg_row(mmot_pkg::REG_TRIG_RE, 32'd1));
    dir_tab.push_back(cfg_row(mmot_pkg::REG_DUR_A, 32'd5));
    dir_tab.push_back(cfg_row(mmot_pkg::REG_COIL, 32'd0));
    dir_tab.push_back(cfg_row(mmot_pkg::REG_MODE, 32'(mmot_pkg::MODE_EDGE)));
    dir_tab.push_back(req_row(mmot_pkg::OP_TICK, 32'd300, 1'b1, 8'd0));
    dir_tab.push_back(req_row(mmot_pkg::OP_TICK, 32'd305, 1'b1, 8'd0));
    dir_tab.push_back(cfg_row(mmot_pkg::REG_TRIG_RE, 32'd0));
    dir_tab.push_back(cfg_row(mmot_pkg::REG_DUR_A, 32'd0));
    dir_tab.push_back(req_row(mmot_pkg::OP_TICK, 32'd310, 1'b1, 8'd0));
    dir_tab.push_back(req_row(mmot_pkg::OP_TICK, 32'd311, 1'b0, 8'd0));
    // coil write start with zero delay parks in phase 0
    dir_tab.push_back(req_row(mmot_pkg::OP_COIL, 32'd312, 1'b0, 8'd0));
    dir_tab.push_back(req_row(mmot_pkg::OP_TICK, 32'd400, 1'b0, 8'd0));
    // unused mode, write past the register list
    dir_tab.push_back(cfg_row(mmot_pkg::REG_MODE, 32'd7));
    dir_tab.push_back(cfg_row(REG_NONE, 32'h1234_5678));
    dir_tab.push_back(chk_row(mmot_pkg::OP_TICK, 32'hFFFF_FFFF, 1'b1, 8'd255, IDLE_RES));
    dir_tab.push_back(chk_row(mmot_pkg::OP_COIL, 32'hFFFF_FFFF, 1'b1, 8'd0, IDLE_RES));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        wait_results_drained();
        write_reg(dir_tab[i].reg_idx, dir_tab[i].value);
      end else begin
        send_req(dir_tab[i].op, dir_tab[i].value, dir_tab[i].level, dir_tab[i].coil,
                 dir_tab[i].typed, dir_tab[i].want);
      end
    end

    stamp = $urandom();
    level = 1'b0;
    for (seg = 0; seg < SEGMENTS; seg++) begin
      wait_results_drained();
      no_gaps <= (seg >= 6 && seg < 9);
      vals[mmot_pkg::REG_MODE]    = ($urandom_range(99) < 85) ? $urandom_range(1, 4)
                                                              : $urandom_range(0, 7);
      vals[mmot_pkg::REG_DUR_A]   = pick_duration();
      vals[mmot_pkg::REG_DUR_B]   = pick_duration();
      vals[mmot_pkg::REG_DUR_C]   = pick_duration();
      vals[mmot_pkg::REG_LEVELS]  = $urandom_range(0, 7);
      vals[mmot_pkg::REG_TRIG_RE] = $urandom_range(0, 1);
      vals[mmot_pkg::REG_COIL]    = $urandom_range(0, 255);
      first = $urandom_range(0, 6);
      for (k = 0; k < 7; k++) begin
        r = (first + k) % 7;
        write_reg(mmot_pkg::REG_W'(r), ($urandom() & ~REG_MASK[r]) | vals[r]);
      end
      if ($urandom_range(3) == 0) write_reg(REG_NONE, $urandom());
      if (seg == HOLD_SEG) hold_toggle <= ~hold_toggle;
      if ($urandom_range(1) == 0) stamp = $urandom();
      for (k = 0; k < SEG_ITEMS; k++) begin
        roll = $urandom_range(99);
        if (roll < 4) stamp = $urandom();
        else if (roll < 6) stamp = 32'hFFFF_FFF0 + $urandom_range(0, 15);
        else stamp = stamp + $urandom_range(0, 6);
        if ($urandom_range(99) < 35) level = ~level;
        if ($urandom_range(99) < 15) begin
          op  = mmot_pkg::OP_COIL;
          idx = ($urandom_range(99) < 80) ? vals[mmot_pkg::REG_COIL][mmot_pkg::COIL_W-1:0]
                                          : mmot_pkg::COIL_W'($urandom());
        end else begin
          op  = mmot_pkg::OP_TICK;
          idx = mmot_pkg::COIL_W'($urandom());
        end
        send_req(op, stamp, level, idx, 1'b0, IDLE_RES);
      end
    end

    wait_results_drained();
    repeat (END_SETTLE) @(posedge clk);
    if (mismatches == 0 && timer_results_q.size() == 0)
      $display("[multi_mode_output_timer_core] OK");
    else
      $display("[multi_mode_output_timer_core] ERROR");
    $finish;
  end

endmodule
